// ===== hw/rtl/u2c_pkg.sv =====
package u2c_pkg;

	localparam int unsigned NUM_STAGES = 11;

	// calendar constants
	localparam int unsigned GA_OFFSET       = 102032;
	localparam int unsigned GREG_CYCLE_DAYS = 146097;
	localparam int unsigned JB_OFFSET       = 2442113;
	localparam int unsigned YC_OFFSET       = 2442;
	localparam int unsigned YC_DIVISOR      = 7305;
	localparam int unsigned ME_DIVISOR      = 30601;
	localparam int unsigned MD_FACTOR       = 601;
	localparam int unsigned YEAR_EARLY      = 4716;
	localparam int unsigned YEAR_LATE       = 4715;
	localparam int unsigned ZELLER_MONTH    = 26;
	localparam int unsigned MONTH_SPLIT     = 13;

	// reciprocal multipliers: floor(n / d) == (n * ceil(2^sh / d)) >> sh for all n below 2^(sh - clog2(d))
	localparam int unsigned    DIV60_SH  = 34;
	localparam logic [30:0]    DIV60_MUL = 31'(((64'd1 << DIV60_SH) + 64'd14) / 64'd15);
	localparam int unsigned    DIVHR_SH  = 29;
	localparam logic [25:0]    DIVHR_MUL = 26'(((64'd1 << DIVHR_SH) + 64'd14) / 64'd15);
	localparam int unsigned    DIVDAY_SH  = 20;
	localparam logic [18:0]    DIVDAY_MUL = 19'(((64'd1 << DIVDAY_SH) + 64'd2) / 64'd3);
	localparam int unsigned    DIVYC_SH  = 39;
	localparam logic [26:0]    DIVYC_MUL = 27'(((64'd1 << DIVYC_SH) + 64'(YC_DIVISOR) - 64'd1)
		/ 64'(YC_DIVISOR));
	localparam int unsigned    DIVME_SH  = 35;
	localparam logic [30:0]    DIVME_MUL = 31'(64'd1000 * (((64'd1 << DIVME_SH)
		+ 64'(ME_DIVISOR) - 64'd1) / 64'(ME_DIVISOR)));
	localparam int unsigned    DIVMD_SH  = 25;
	localparam logic [24:0]    DIVMD_MUL = 25'(64'(MD_FACTOR) * (((64'd1 << DIVMD_SH)
		+ 64'd999) / 64'd1000));
	localparam int unsigned    DIVCENT_SH  = 19;
	localparam logic [12:0]    DIVCENT_MUL = 13'(((64'd1 << DIVCENT_SH) + 64'd99) / 64'd100);
	localparam int unsigned    DIVMP_SH  = 13;
	localparam logic [14:0]    DIVMP_MUL = 15'(64'(ZELLER_MONTH) * (((64'd1 << DIVMP_SH)
		+ 64'd9) / 64'd10));
	localparam int unsigned    DIV7_SH  = 12;
	localparam logic [9:0]     DIV7_MUL = 10'(((64'd1 << DIV7_SH) + 64'd6) / 64'd7);

	typedef struct packed {
		logic signed [32:0] unix_seconds;
	} u2c_in_t;

	typedef struct packed {
		logic [5:0]  second_of_minute;
		logic [5:0]  minute_of_hour;
		logic [4:0]  hour_of_day;
		logic [4:0]  day_of_month;
		logic [3:0]  month_of_year;
		logic [11:0] calendar_year;
		logic [2:0]  weekday;
	} u2c_out_t;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
	} u2c_time_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} u2c_date_t;

endpackage

// ===== hw/rtl/u2c_stream_if.sv =====
interface u2c_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/u2c_tod.sv =====
module u2c_tod
	import u2c_pkg::*;
(
	input  logic               clk,
	input  logic [3:0]         en,
	input  logic signed [32:0] seconds,
	output logic [15:0]        days_s3,
	output u2c_time_t          time_s4
);
	logic [31:0] t;
	logic [60:0] prod_min;
	logic [26:0] tmin_s1;
	logic [5:0]  tlow_s1;
	logic [11:0] sec_sub;
	logic [50:0] prod_hr;
	logic [5:0]  sec_s2;
	logic [5:0]  mlow_s2;
	logic [20:0] thour_s2;
	logic [11:0] min_sub;
	logic [36:0] prod_day;
	logic [5:0]  sec_s3;
	logic [5:0]  min_s3;
	logic [4:0]  hlow_s3;
	logic [9:0]  hr_sub;

	// negative timestamps clamp to the epoch
	assign t        = seconds[32] ? 32'd0 : seconds[31:0];
	assign prod_min = 61'(t[31:2]) * 61'(DIV60_MUL);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tmin_s1 <= prod_min[DIV60_SH +: 27];
			tlow_s1 <= t[5:0];
		end
	end

	// only the low bits matter, the remainder is below 64
	assign sec_sub = 12'(tmin_s1[5:0]) * 12'd60;
	assign prod_hr = 51'(tmin_s1[26:2]) * 51'(DIVHR_MUL);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sec_s2   <= tlow_s1 - sec_sub[5:0];
			mlow_s2  <= tmin_s1[5:0];
			thour_s2 <= prod_hr[DIVHR_SH +: 21];
		end
	end

	assign min_sub  = 12'(thour_s2[5:0]) * 12'd60;
	assign prod_day = 37'(thour_s2[20:3]) * 37'(DIVDAY_MUL);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sec_s3  <= sec_s2;
			min_s3  <= mlow_s2 - min_sub[5:0];
			hlow_s3 <= thour_s2[4:0];
			days_s3 <= prod_day[DIVDAY_SH +: 16];
		end
	end

	assign hr_sub = 10'(days_s3[4:0]) * 10'd24;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			time_s4.second <= sec_s3;
			time_s4.minute <= min_s3;
			time_s4.hour   <= hlow_s3 - hr_sub[4:0];
		end
	end
endmodule

// ===== hw/rtl/u2c_date.sv =====
module u2c_date
	import u2c_pkg::*;
(
	input  logic        clk,
	input  logic [4:0]  en,
	input  logic [15:0] days_s3,
	input  u2c_time_t   time_s4,
	output u2c_date_t   date_s8,
	output u2c_time_t   time_s8
);
	logic [18:0] ga_arg;
	logic [1:0]  ga_base;
	logic [4:0]  ga;
	logic [4:0]  ga_corr;
	logic [21:0] jb_s4;
	logic [25:0] yc_arg;
	logic [52:0] prod_yc;
	logic [13:0] yc_s5;
	logic [21:0] jb_s5;
	u2c_time_t   time_s5;
	logic [21:0] dd_full;
	logic [9:0]  dd_s6;
	logic [13:0] yc_s6;
	u2c_time_t   time_s6;
	logic [40:0] prod_me;
	logic [4:0]  me_s7;
	logic [9:0]  dd_s7;
	logic [13:0] yc_s7;
	u2c_time_t   time_s7;
	logic [29:0] prod_md;
	logic [9:0]  md_full;
	logic [13:0] yr_full;
	logic [4:0]  mo_full;

	assign ga_arg = {1'b0, days_s3, 2'b00} + 19'(GA_OFFSET);

	// the scaled day count stays below three Gregorian cycles, so the quotient is 0, 1 or 2
	always_comb begin
		priority if (ga_arg >= 19'(2 * GREG_CYCLE_DAYS)) begin
			ga_base = 2'd2;
		end else if (ga_arg >= 19'(GREG_CYCLE_DAYS)) begin
			ga_base = 2'd1;
		end else begin
			ga_base = 2'd0;
		end
	end

	assign ga      = 5'(ga_base) + 5'd15;
	assign ga_corr = ga - (ga >> 2);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			jb_s4 <= 22'(days_s3) + 22'(JB_OFFSET) + 22'(ga_corr);
		end
	end

	// 20 * jb as shift-add
	assign yc_arg  = {jb_s4, 4'b0000} + 26'({jb_s4, 2'b00}) - 26'(YC_OFFSET);
	assign prod_yc = 53'(yc_arg) * 53'(DIVYC_MUL);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			yc_s5   <= prod_yc[DIVYC_SH +: 14];
			jb_s5   <= jb_s4;
			time_s5 <= time_s4;
		end
	end

	assign dd_full = jb_s5 - 22'(yc_s5) * 22'd365 - 22'(yc_s5[13:2]);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dd_s6   <= dd_full[9:0];
			yc_s6   <= yc_s5;
			time_s6 <= time_s5;
		end
	end

	assign prod_me = 41'(dd_s6) * 41'(DIVME_MUL);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			me_s7   <= prod_me[DIVME_SH +: 5];
			dd_s7   <= dd_s6;
			yc_s7   <= yc_s6;
			time_s7 <= time_s6;
		end
	end

	assign prod_md = 30'(me_s7) * 30'(DIVMD_MUL);
	assign md_full = dd_s7 - 10'(me_s7) * 10'd30 - 10'(prod_md[DIVMD_SH +: 4]);

	// march-based months wrap into the next year after month thirteen
	always_comb begin
		if (me_s7 <= 5'(MONTH_SPLIT)) begin
			yr_full = yc_s7 - 14'(YEAR_EARLY);
			mo_full = me_s7 - 5'd1;
		end else begin
			yr_full = yc_s7 - 14'(YEAR_LATE);
			mo_full = me_s7 - 5'(MONTH_SPLIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			date_s8.day   <= md_full[4:0];
			date_s8.month <= mo_full[3:0];
			date_s8.year  <= yr_full[11:0];
			time_s8       <= time_s7;
		end
	end
endmodule

// ===== hw/rtl/u2c_wday.sv =====
module u2c_wday
	import u2c_pkg::*;
(
	input  logic       clk,
	input  logic [2:0] en,
	input  u2c_date_t  date_s8,
	input  u2c_time_t  time_s8,
	output u2c_out_t   result_s11
);
	logic [11:0] zy;
	logic [3:0]  zm;
	logic [24:0] prod_cent;
	logic [4:0]  cent_s9;
	logic [11:0] zy_s9;
	logic [3:0]  zm_s9;
	u2c_date_t   date_s9;
	u2c_time_t   time_s9;
	logic [11:0] yoc_full;
	logic [6:0]  yoc;
	logic [18:0] prod_mp;
	logic [8:0]  h_sum;
	logic [8:0]  hp_s10;
	u2c_date_t   date_s10;
	u2c_time_t   time_s10;
	logic [18:0] prod_q7;
	logic [8:0]  rem7;

	// january and february count as months 13 and 14 of the year before
	always_comb begin
		if (date_s8.month <= 4'd2) begin
			zm = date_s8.month + 4'd12;
			zy = date_s8.year - 12'd1;
		end else begin
			zm = date_s8.month;
			zy = date_s8.year;
		end
	end

	assign prod_cent = 25'(zy) * 25'(DIVCENT_MUL);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cent_s9 <= prod_cent[DIVCENT_SH +: 5];
			zy_s9   <= zy;
			zm_s9   <= zm;
			date_s9 <= date_s8;
			time_s9 <= time_s8;
		end
	end

	assign yoc_full = zy_s9 - 12'(cent_s9) * 12'd100;
	assign yoc      = yoc_full[6:0];
	assign prod_mp  = 19'(zm_s9 + 4'd1) * 19'(DIVMP_MUL);

	// zeller sum plus the shift that puts monday at zero
	assign h_sum = 9'(date_s9.day) + 9'(prod_mp[DIVMP_SH +: 6]) + 9'(yoc) + 9'(yoc[6:2])
		+ 9'(cent_s9) * 9'd5 + 9'(cent_s9[4:2]) + 9'd5;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hp_s10   <= h_sum;
			date_s10 <= date_s9;
			time_s10 <= time_s9;
		end
	end

	assign prod_q7 = 19'(hp_s10) * 19'(DIV7_MUL);
	assign rem7    = hp_s10 - 9'(prod_q7[DIV7_SH +: 6]) * 9'd7;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			result_s11.second_of_minute <= time_s10.second;
			result_s11.minute_of_hour   <= time_s10.minute;
			result_s11.hour_of_day      <= time_s10.hour;
			result_s11.day_of_month     <= date_s10.day;
			result_s11.month_of_year    <= date_s10.month;
			result_s11.calendar_year    <= date_s10.year;
			result_s11.weekday          <= rem7[2:0] + 3'd1;
		end
	end
endmodule

// ===== hw/rtl/unix_seconds_to_calendar_date_top.sv =====
// each accepted request passes through one register per stage on the way to its result
// throughput: one request per cycle while the output is not stalled; each stage holds at most one reciprocal multiply
// a stalled output backs up stage by stage, bubbles are squeezed out on the way
// reset clears the stage valid bits only, datapath registers are not reset
module unix_seconds_to_calendar_date_top
	import u2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	u2c_stream_if.sink   ts_in,
	u2c_stream_if.source date_out
);
	logic [NUM_STAGES:1] en;
	logic [NUM_STAGES:1] stage_valid_q;
	logic [15:0]         days_s3;
	u2c_time_t           time_s4;
	u2c_date_t           date_s8;
	u2c_time_t           time_s8;
	u2c_out_t            result_s11;

	// a stage may load when it is empty or its successor loads too
	always_comb begin
		en[NUM_STAGES] = !stage_valid_q[NUM_STAGES] || date_out.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = !stage_valid_q[k] || en[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[1]) begin
				stage_valid_q[1] <= ts_in.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					stage_valid_q[k] <= stage_valid_q[k - 1];
				end
			end
		end
	end

	assign ts_in.ready      = en[1];
	assign date_out.valid   = stage_valid_q[NUM_STAGES];
	assign date_out.payload = result_s11;

	u2c_tod u_tod (
		.clk     (clk),
		.en      (en[4:1]),
		.seconds (ts_in.payload.unix_seconds),
		.days_s3 (days_s3),
		.time_s4 (time_s4)
	);

	u2c_date u_date (
		.clk     (clk),
		.en      (en[8:4]),
		.days_s3 (days_s3),
		.time_s4 (time_s4),
		.date_s8 (date_s8),
		.time_s8 (time_s8)
	);

	u2c_wday u_wday (
		.clk        (clk),
		.en         (en[11:9]),
		.date_s8    (date_s8),
		.time_s8    (time_s8),
		.result_s11 (result_s11)
	);

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!date_out.valid |-> ts_in.ready)
		else $error("input stalled while the output stage is empty");

	a_request_enters: assert property (@(posedge clk) disable iff (!arst_n)
		ts_in.valid && ts_in.ready |=> stage_valid_q[1])
		else $error("accepted request did not reach the first stage");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid |-> date_out.payload.second_of_minute <= 6'd59
			&& date_out.payload.minute_of_hour <= 6'd59
			&& date_out.payload.hour_of_day <= 5'd23)
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid |-> date_out.payload.day_of_month >= 5'd1
			&& date_out.payload.month_of_year >= 4'd1
			&& date_out.payload.month_of_year <= 4'd12
			&& date_out.payload.calendar_year >= 12'd1970
			&& date_out.payload.calendar_year <= 12'd2106)
		else $error("calendar date out of range");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		date_out.valid |-> date_out.payload.weekday != 3'd0)
		else $error("weekday out of range");
endmodule

// ===== tb/u2c_date_checker.sv =====
`timescale 1ns / 1ps

module u2c_date_checker
	import u2c_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  u2c_in_t     req,
	input  logic        date_valid,
	input  logic        date_ready,
	input  u2c_out_t    date,
	output int unsigned outstanding,
	output int unsigned failures
);

	u2c_out_t    expected_dates[$];
	int unsigned fail_count = 0;

	// Zeller's congruence, shifted so that 1 is Monday
	function automatic logic [2:0] weekday_of(longint unsigned yr, longint unsigned mo,
		longint unsigned dy);
		longint unsigned cent, yoc, h;
		if (mo <= 2) begin
			mo += 12;
			yr -= 1;
		end
		cent = yr / 100;
		yoc  = yr % 100;
		h = dy + (26 * (mo + 1)) / 10 + yoc + yoc / 4 + 5 * cent + cent / 4;
		return 3'(((h + 5) % 7) + 1);
	endfunction

	function automatic u2c_out_t civil_date_of(logic signed [32:0] stamp);
		longint unsigned secs, days, ga, jb, yc, dd, me, md;
		u2c_out_t r;
		// anything before the epoch is pinned to it
		secs = stamp[32] ? 64'd0 : {32'd0, stamp[31:0]};
		r.second_of_minute = 6'(secs % 60);
		secs /= 60;
		r.minute_of_hour = 6'(secs % 60);
		secs /= 60;
		r.hour_of_day = 5'(secs % 24);
		days = secs / 24;

		ga = (4 * days + 102032) / 146097 + 15;
		jb = days + 2442113 + ga - ga / 4;
		yc = (20 * jb - 2442) / 7305;
		dd = jb - 365 * yc - yc / 4;
		me = (dd * 1000) / 30601;
		md = dd - me * 30 - (me * 601) / 1000;
		// march-based year: january and february belong to the next one
		if (me <= 13) begin
			yc -= 4716;
			me -= 1;
		end else begin
			yc -= 4715;
			me -= 13;
		end
		r.day_of_month  = 5'(md);
		r.month_of_year = 4'(me);
		r.calendar_year = 12'(yc);
		r.weekday       = weekday_of(yc, me, md);
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		u2c_out_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_dates.push_back(civil_date_of(req.unix_seconds));
			if (date_valid && date_ready) begin
				if (expected_dates.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected date, expected none, got %0d-%0d-%0d",
						$time, date.calendar_year, date.month_of_year, date.day_of_month);
				end else begin
					want = expected_dates.pop_front();
					check_field("second_of_minute", want.second_of_minute,
						date.second_of_minute);
					check_field("minute_of_hour", want.minute_of_hour, date.minute_of_hour);
					check_field("hour_of_day", want.hour_of_day, date.hour_of_day);
					check_field("day_of_month", want.day_of_month, date.day_of_month);
					check_field("month_of_year", want.month_of_year, date.month_of_year);
					check_field("calendar_year", want.calendar_year, date.calendar_year);
					check_field("weekday", want.weekday, date.weekday);
				end
			end
		end
		outstanding <= expected_dates.size();
		failures    <= fail_count;
	end

endmodule

// ===== tb/unix_seconds_to_calendar_date_top_tb.sv =====
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_top_tb;
	import u2c_pkg::*;

	localparam int unsigned RANDOM_REQUESTS = 830;
	localparam int unsigned HOLD_CYCLES     = 200;
	localparam int unsigned HOLD_AT         = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned outstanding;
	int unsigned failures;
	bit          hold_req  = 1'b0;
	bit          hold_done = 1'b0;

	u2c_stream_if #(.payload_t(u2c_in_t))  ts_in_if ();
	u2c_stream_if #(.payload_t(u2c_out_t)) date_out_if ();

	unix_seconds_to_calendar_date_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.ts_in    (ts_in_if),
		.date_out (date_out_if)
	);

	u2c_date_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (ts_in_if.valid),
		.req_ready   (ts_in_if.ready),
		.req         (ts_in_if.payload),
		.date_valid  (date_out_if.valid),
		.date_ready  (date_out_if.ready),
		.date        (date_out_if.payload),
		.outstanding (outstanding),
		.failures    (failures)
	);

	always #1 clk = ~clk;

	// around the epoch, leap days incl. the non-leap 2100, the 2^31 boundary, 33-bit extremes
	logic [32:0] corner_stamps [20] = '{
		33'd0, 33'd1, 33'd59, 33'd60, 33'd3599, 33'd3600, 33'd86399, 33'd86400,
		33'd31535999, 33'd31536000, 33'd68169600, 33'd951782400, 33'd951868800,
		33'd4107456000, 33'd4107542400, 33'd946684799, 33'd2147483647,
		33'h0_FFFF_FFFF, 33'h1_FFFF_FFFF, 33'h1_0000_0000
	};

	function automatic logic [32:0] draw_stamp();
		int unsigned pick;
		longint unsigned days, offset;
		pick = $urandom_range(0, 19);
		if (pick < 11)
			return {1'b0, 32'($urandom)};
		if (pick < 14)
			return {1'b1, 32'($urandom)};
		// land on or right beside a midnight, or anywhere in a random day
		days = $urandom_range(0, 49709);
		case ($urandom_range(0, 3))
			0: offset = 0;
			1: offset = 86399;
			2: offset = 1;
			default: offset = $urandom_range(0, 86399);
		endcase
		return {1'b0, 32'(days * 86400 + offset)};
	endfunction

	task automatic send_stamp(input logic [32:0] stamp, input int unsigned gap);
		if (gap != 0) begin
			ts_in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ts_in_if.valid                <= 1'b1;
		ts_in_if.payload.unix_seconds <= stamp;
		do @(posedge clk); while (!ts_in_if.ready);
		@(negedge clk);
	endtask

	initial begin : request_source
		int unsigned sent;
		bit          gappy;
		ts_in_if.valid   = 1'b0;
		ts_in_if.payload = '0;
		arst_n           = 1'b0;
		sent  = 0;
		gappy = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corner_stamps[i]) begin
			send_stamp(corner_stamps[i], $urandom_range(0, 2));
			sent++;
		end
		repeat (RANDOM_REQUESTS) begin
			if (sent % 50 == 0)
				gappy = $urandom_range(0, 2) != 0;
			if (sent == HOLD_AT) begin
				hold_req = 1'b1;
				gappy    = 1'b0;
			end
			send_stamp(draw_stamp(), gappy ? $urandom_range(0, 6) : 0);
			sent++;
		end
		ts_in_if.valid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (20) @(negedge clk);
		if (failures == 0)
			$display("unix_seconds_to_calendar_date_top_tb: done, clean");
		else
			$display("unix_seconds_to_calendar_date_top_tb: done, errors");
		$finish;
	end

	initial begin : result_sink
		int unsigned stall, taken;
		bit          stalling;
		date_out_if.ready = 1'b0;
		taken    = 0;
		stalling = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 40 == 0)
				stalling = $urandom_range(0, 2) != 0;
			stall = stalling ? $urandom_range(0, 6) : 0;
			// one long back-pressure window so the pipeline fills and stalls its input
			if (hold_req && !hold_done) begin
				stall     = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall != 0) begin
				date_out_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			date_out_if.ready <= 1'b1;
			do @(posedge clk); while (!date_out_if.valid);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : watchdog
		#200000;
		$display("unix_seconds_to_calendar_date_top_tb: done, errors");
		$finish;
	end

endmodule
